// ----- hdl/sidtoa_pkg.sv -----
// ----------------------------------------------------------------------------
// sidtoa_pkg
// Shared types and constants for the signed integer to decimal ASCII unit.
// ----------------------------------------------------------------------------
package sidtoa_pkg;

  localparam int VALUE_BITS = 32;
  // Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
  localparam int DIGITS     = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_BITS   = DIGITS * 4;
  localparam int IDX_W      = $clog2(DIGITS);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int CHAR_BITS  = 7;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'd45;

  typedef logic [VALUE_BITS-1:0] mag_t;
  typedef logic [BCD_BITS-1:0]   bcd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_e;

endpackage

// ----- hdl/sidtoa_ifs.sv -----
// ----------------------------------------------------------------------------
// sidtoa channel interfaces
// Valid/ready channels for the number input and the character output.
// ----------------------------------------------------------------------------
interface sidtoa_in_if import sidtoa_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidtoa_out_if import sidtoa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] character;
  logic                 last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- hdl/sidtoa_dabble.sv -----
// ----------------------------------------------------------------------------
// sidtoa_dabble
// Iterative shift-add-3 binary to BCD converter, one bit per cycle.
// ----------------------------------------------------------------------------
module sidtoa_dabble import sidtoa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  mag_t mag_i,
  output logic done_o,
  output bcd_t bcd_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  mag_t             bin_q, bin_d;
  bcd_t             bcd_q, bcd_d;
  bcd_t             adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_BITS);
      bin_d  = mag_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      bcd_d = {adj[BCD_BITS-2:0], bin_q[VALUE_BITS-1]};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ----- hdl/signed_int_to_decimal_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Renders a signed integer as decimal ASCII text, most significant first.
//
//   channel | dir | payload            | handshake
//   in_i    | in  | value[31:0] signed | valid/ready
//   out_o   | out | character[6:0],last| valid/ready
//
// One number is accepted, converted in the BCD unit by shift-add-3 over all
// VALUE_BITS bits, scanned past leading zeros, then sent as one character
// per cycle while the output is not stalled, with a leading minus for a
// negative number.
// in_i.ready is high only while idle. Output stalls hold the character
// register and pause the sequencer. Reset clears all control state.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit import sidtoa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sidtoa_in_if.sink   in_i,
  sidtoa_out_if.source out_o
);

  state_e               state_q, state_d;
  logic                 neg_q, neg_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 ovalid_q, ovalid_d;
  logic [CHAR_BITS-1:0] char_q, char_d;
  logic                 last_q, last_d;

  logic                 start;
  mag_t                 raw, mag;
  logic                 done;
  bcd_t                 bcd;
  logic [3:0]           nib;
  logic                 load_ok;

  assign raw     = mag_t'(in_i.value);
  assign mag     = raw[VALUE_BITS-1] ? (~raw + mag_t'(1)) : raw;
  assign nib     = bcd[idx_q*4 +: 4];
  assign load_ok = !ovalid_q || out_o.ready;

  sidtoa_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mag_i   (mag),
    .done_o  (done),
    .bcd_o   (bcd)
  );

  always_comb begin
    state_d    = state_q;
    neg_d      = neg_q;
    idx_d      = idx_q;
    ovalid_d   = ovalid_q;
    char_d     = char_q;
    last_d     = last_q;
    start      = 1'b0;
    in_i.ready = 1'b0;
    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          start   = 1'b1;
          neg_d   = raw[VALUE_BITS-1];
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (done) begin
          idx_d   = IDX_W'(DIGITS - 1);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (idx_q != '0 && nib == 4'd0) begin
          idx_d = idx_q - IDX_W'(1);
        end else if (neg_q) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (load_ok) begin
          ovalid_d = 1'b1;
          char_d   = CHAR_MINUS;
          last_d   = 1'b0;
          state_d  = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (load_ok) begin
          ovalid_d = 1'b1;
          char_d   = CHAR_ZERO + {3'b000, nib};
          last_d   = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      neg_q    <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      neg_q    <= neg_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

endmodule
